FILE: rtl/battery_status_aggregator_defines.svh
// Assertion macros shared by the battery status aggregator RTL.
`ifndef BATTERY_STATUS_AGGREGATOR_DEFINES_SVH
`define BATTERY_STATUS_AGGREGATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("battery status aggregator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("battery status aggregator: next-cycle check failed");

`endif

FILE: rtl/bsa_pkg.sv
// Types and constants shared by the battery status aggregator modules.
package bsa_pkg;

   // Field widths of one input item and one result item.
   localparam int CELL_W    = 16;
   localparam int ID_W      = 8;
   localparam int CUR_W     = 16;
   localparam int CHG_W     = 8;
   localparam int VOLT_W    = 20;
   localparam int TOTCUR_W  = 20;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int ENTRY_W   = CUR_W + CHG_W;

   // Scan sum width: 256 entries of 16-bit signed values plus headroom.
   localparam int SUM_W = 25;

   localparam logic [CELL_W-1:0] CELL_ABSENT = 16'hFFFF;
   localparam logic [VOLT_W-1:0] VOLT_MAX    = 20'hFFFFF;
   localparam logic [TOTCUR_W-1:0] TOTCUR_POS_SAT = 20'h7FFFF;
   localparam logic [TOTCUR_W-1:0] TOTCUR_NEG_SAT = 20'h80000;
   localparam logic signed [SUM_W-1:0] SUM_CUR_MAX = 25'sd524287;
   localparam logic signed [SUM_W-1:0] SUM_CUR_MIN = -25'sd524288;

   // Controller states.
   typedef enum logic [1:0] {
      ST_RUN,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } bsa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic scan_start;
      logic scan_read;
      logic load_out;
   } bsa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;
   } bsa_status_type;

endpackage

FILE: rtl/battery_status_aggregator.sv
// Battery status aggregator top level: report intake, table totals, result channel.
// Cell items are taken one per cycle, except from a closing item until the result load.
// After the closing item the table is scanned one entry per cycle through the RAM
// read port, and the result is loaded once the result register is free.
// No item is taken during the scan; a held result blocks intake only while a load waits.
// Synchronous reset clears the report state, the table valid bits and the handshake.
`include "battery_status_aggregator_defines.svh"

module battery_status_aggregator #(
   parameter int MAX_BATTERIES = 16,
   parameter int MAIN_CELLS    = 10,
   parameter int EXT_CELLS     = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // Fields from bit 0: cell_mv[15:0], battery_id[23:16], current_ca[39:24],
   // charge code[47:40].
   input  logic [bsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tlast,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: total_voltage_mv[19:0], voltage_valid[20],
   // total_current_ca[40:21], worst_state[48:41], id_rejected[49], zero fill.
   output logic [bsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);

   import bsa_pkg::*;

   bsa_cmd_type    cmd;
   bsa_status_type status;

   bsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   bsa_datapath #(
      .MAX_BATTERIES (MAX_BATTERIES),
      .MAIN_CELLS    (MAIN_CELLS),
      .EXT_CELLS     (EXT_CELLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

   // A closing item starts the scan, which holds off intake.
   `BSA_ASSERT_NEXT(a_last_stops_intake, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
   // The result register is loaded only when it is empty or being emptied.
   `BSA_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_out, !rsp_tvalid || rsp_tready)
   // Table reads never overlap item intake.
   `BSA_ASSERT_SAME(a_scan_no_intake, clock, reset, cmd.scan_read, !req_tready)

endmodule

FILE: rtl/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bsa_ctrl.sv
// Controller state machine: item intake, table scan sequencing, result load.
module bsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output bsa_pkg::bsa_cmd_type    cmd,
   input  bsa_pkg::bsa_status_type status
);

   import bsa_pkg::*;

   bsa_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd.take_item  = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_read  = 1'b0;
      cmd.load_out   = 1'b0;
      req_tready     = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               if (req_tlast) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last table read lands in the accumulators here.
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      // The result register fills on load and empties when the item is taken.
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/bsa_datapath.sv
// Datapath: cell voltage runs, battery table, table scan and result register.
module bsa_datapath #(
   parameter int MAX_BATTERIES = 16,
   parameter int MAIN_CELLS    = 10,
   parameter int EXT_CELLS     = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [bsa_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tlast,
   output logic [bsa_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  bsa_pkg::bsa_cmd_type                 cmd,
   output bsa_pkg::bsa_status_type              status
);

   import bsa_pkg::*;

   localparam int TOTAL_CELLS = MAIN_CELLS + EXT_CELLS;
   localparam int POS_W = $clog2(TOTAL_CELLS + 1);
   localparam int IDX_W = (MAX_BATTERIES > 1) ? $clog2(MAX_BATTERIES) : 1;
   localparam logic [POS_W-1:0] MAIN_POS  = POS_W'(MAIN_CELLS);
   localparam logic [POS_W-1:0] TOTAL_POS = POS_W'(TOTAL_CELLS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_BATTERIES - 1);
   localparam logic [ID_W:0]    ID_LIMIT  = (ID_W + 1)'(MAX_BATTERIES);

   // Input item fields.
   logic [CELL_W-1:0] cell_mv;
   logic [ID_W-1:0]   battery_id;
   logic [CUR_W-1:0]  current_ca;
   logic [CHG_W-1:0]  chg_code;

   assign cell_mv    = req_tdata[15:0];
   assign battery_id = req_tdata[23:16];
   assign current_ca = req_tdata[39:24];
   assign chg_code   = req_tdata[47:40];

   // Report state.
   logic [VOLT_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              main_end_ff, main_end_in;
   logic              ext_end_ff, ext_end_in;
   logic              first_ff, first_in;
   logic              absent;
   logic [VOLT_W:0]   acc_sum;
   logic [VOLT_W-1:0] acc_sat;
   logic              rejected;

   // Values held from the closing item until the result is loaded.
   logic [VOLT_W-1:0] volt_hold_ff;
   logic              vvalid_hold_ff;
   logic              rej_hold_ff;

   // Table and scan.
   logic [MAX_BATTERIES-1:0]  valid_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic                      rd_pend_ff;
   logic                      rd_valid_ff;
   logic [ENTRY_W-1:0]        rd_data;
   logic signed [CUR_W-1:0]   rd_cur;
   logic [CHG_W-1:0]          rd_chg;
   logic signed [SUM_W-1:0]   sum_ff;
   logic [CHG_W-1:0]          worst_ff;
   logic [TOTCUR_W-1:0]       sum_sat;
   logic                      wr_en;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;

   // Fold one cell into the leading runs of main and extended cells.
   always_comb begin
      absent      = (cell_mv == CELL_ABSENT);
      acc_sum     = {1'b0, acc_ff} + (VOLT_W + 1)'(cell_mv);
      acc_sat     = acc_sum[VOLT_W] ? VOLT_MAX : acc_sum[VOLT_W-1:0];
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      main_end_in = main_end_ff;
      ext_end_in  = ext_end_ff;
      first_in    = first_ff;
      if (pos_ff < MAIN_POS) begin
         if (pos_ff == '0) begin
            first_in = !absent;
         end
         if (absent) begin
            main_end_in = 1'b1;
         end else if (!main_end_ff) begin
            acc_in = acc_sat;
         end
      end else if (pos_ff < TOTAL_POS) begin
         if (absent) begin
            ext_end_in = 1'b1;
         end else if (!ext_end_ff) begin
            acc_in = acc_sat;
         end
      end
      if (pos_ff < TOTAL_POS) begin
         pos_in = pos_ff + 1'b1;
      end
      rejected = ({1'b0, battery_id} >= ID_LIMIT);
   end

   // Report state registers; a closing item clears them for the next report.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff      <= '0;
         pos_ff      <= '0;
         main_end_ff <= 1'b0;
         ext_end_ff  <= 1'b0;
         first_ff    <= 1'b0;
      end else if (cmd.take_item) begin
         if (req_tlast) begin
            acc_ff      <= '0;
            pos_ff      <= '0;
            main_end_ff <= 1'b0;
            ext_end_ff  <= 1'b0;
            first_ff    <= 1'b0;
         end else begin
            acc_ff      <= acc_in;
            pos_ff      <= pos_in;
            main_end_ff <= main_end_in;
            ext_end_ff  <= ext_end_in;
            first_ff    <= first_in;
         end
      end
   end

   // Capture the voltage and id verdict of the closing item.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         volt_hold_ff   <= first_in ? acc_in : '0;
         vvalid_hold_ff <= first_in;
         rej_hold_ff    <= rejected;
      end
   end

   // Table write on an accepted id; valid bits stand for the cleared state.
   assign wr_en = cmd.scan_start && !rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[battery_id[IDX_W-1:0]] <= 1'b1;
      end
   end

   bsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BATTERIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (battery_id[IDX_W-1:0]),
      .wr_data ({chg_code, current_ca}),
      .rd_en   (cmd.scan_read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Scan address and read tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan_read;
         if (cmd.scan_start) begin
            idx_ff <= '0;
         end else if (cmd.scan_read) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_read) begin
         rd_valid_ff <= valid_ff[idx_ff];
      end
   end

   assign status.scan_end = (idx_ff == LAST_IDX);
   assign rd_cur = signed'(rd_data[CUR_W-1:0]);
   assign rd_chg = rd_data[ENTRY_W-1:CUR_W];

   // Sum of currents and largest charge state, one entry a cycle.
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         sum_ff   <= '0;
         worst_ff <= '0;
      end else if (rd_pend_ff && rd_valid_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_cur);
         if (rd_chg > worst_ff) begin
            worst_ff <= rd_chg;
         end
      end
   end

   // Saturate the current sum to the result range.
   always_comb begin
      if (sum_ff > SUM_CUR_MAX) begin
         sum_sat = TOTCUR_POS_SAT;
      end else if (sum_ff < SUM_CUR_MIN) begin
         sum_sat = TOTCUR_NEG_SAT;
      end else begin
         sum_sat = sum_ff[TOTCUR_W-1:0];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {6'b0, rej_hold_ff, worst_ff, sum_sat, vvalid_hold_ff, volt_hold_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
